/* sv/rsi_pkg.sv */
// shared types and constants for the ray/sphere intersection pipeline
// no dependencies
package rsi_pkg;

  localparam int CRD_W      = 32;
  localparam int DIR_W      = 18;
  localparam int T_W        = 31;
  localparam int U_W        = 37;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 28;
  localparam int RAD_W      = 48;
  localparam int SQ_STEPS   = 6;
  localparam int SQ_BITS    = 4;
  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 40;
  localparam logic [T_W-1:0] RSQ_RESET = 31'd65536;

  typedef enum logic [2:0] {
    REG_CENTRE_X = 3'd0,
    REG_CENTRE_Y = 3'd1,
    REG_CENTRE_Z = 3'd2,
    REG_RADIUS_SQ = 3'd3,
    REG_MIN_T_FLOOR = 3'd4
  } cfg_reg_e;

  // what travels behind the geometry front end
  typedef struct packed {
    logic                  miss;
    logic [T_W-1:0]        disc;
    logic signed [U_W-1:0] u;
    logic [T_W-1:0]        t_lo;
    logic [T_W-1:0]        t_hi;
  } geo_t;

  // square root state between steps
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    geo_t              ctx;
  } sq_t;

endpackage

/* sv/rsi_geom.sv */
// geometry front end: projection, closest point offset, discriminant
// depends on rsi_pkg
module rsi_geom (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [rsi_pkg::CRD_W-1:0]    centre_x,
  input  logic signed [rsi_pkg::CRD_W-1:0]    centre_y,
  input  logic signed [rsi_pkg::CRD_W-1:0]    centre_z,
  input  logic [rsi_pkg::T_W-1:0]             radius_sq,
  input  logic [rsi_pkg::T_W-1:0]             min_t_floor,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rsi_pkg::CRD_W-1:0]    origin_x,
  input  logic signed [rsi_pkg::CRD_W-1:0]    origin_y,
  input  logic signed [rsi_pkg::CRD_W-1:0]    origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]    dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]    dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]    dir_z,
  input  logic [rsi_pkg::T_W-1:0]             t_min,
  input  logic [rsi_pkg::T_W-1:0]             t_max,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rsi_pkg::geo_t                       out_geo
);
  import rsi_pkg::*;

  logic [7:1] v;
  logic [8:1] rdy;

  logic signed [32:0] d1 [3];
  logic signed [DIR_W-1:0] dr1 [3];
  logic [T_W-1:0] tlo1, thi1;

  logic signed [50:0] pr2 [3];
  logic signed [32:0] d2 [3];
  logic signed [DIR_W-1:0] dr2 [3];
  logic [T_W-1:0] tlo2, thi2;

  logic signed [U_W-1:0] u3;
  logic signed [32:0] d3 [3];
  logic signed [DIR_W-1:0] dr3 [3];
  logic [T_W-1:0] tlo3, thi3;

  logic signed [54:0] q4 [3];
  logic signed [32:0] d4 [3];
  logic signed [U_W-1:0] u4;
  logic [T_W-1:0] tlo4, thi4;

  logic signed [24:0] e5 [3];
  logic far5;
  logic signed [U_W-1:0] u5;
  logic [T_W-1:0] tlo5, thi5;

  logic [47:0] sq6 [3];
  logic far6;
  logic signed [U_W-1:0] u6;
  logic [T_W-1:0] tlo6, thi6;

  logic signed [52:0] sum3;
  logic signed [39:0] e_full [3];
  logic far_c;
  logic [49:0] sum7;
  logic signed [35:0] disc7;
  geo_t geo_next;

  always_comb begin
    rdy[8] = out_ready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: offset to centre, effective minimum distance
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d1[0] <= 33'(centre_x) - 33'(origin_x);
      d1[1] <= 33'(centre_y) - 33'(origin_y);
      d1[2] <= 33'(centre_z) - 33'(origin_z);
      dr1[0] <= dir_x;
      dr1[1] <= dir_y;
      dr1[2] <= dir_z;
      tlo1 <= (min_t_floor > t_min) ? min_t_floor : t_min;
      thi1 <= t_max;
    end
  end

  // stage 2: dot product terms
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        pr2[i] <= 51'(d1[i]) * 51'(dr1[i]);
      end
      d2 <= d1;
      dr2 <= dr1;
      tlo2 <= tlo1;
      thi2 <= thi1;
    end
  end

  // stage 3: projection u
  assign sum3 = 53'(pr2[0]) + 53'(pr2[1]) + 53'(pr2[2]);
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      u3 <= sum3[52:16];
      d3 <= d2;
      dr3 <= dr2;
      tlo3 <= tlo2;
      thi3 <= thi2;
    end
  end

  // stage 4: closest point along the direction
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        q4[i] <= 55'(dr3[i]) * 55'(u3);
      end
      d4 <= d3;
      u4 <= u3;
      tlo4 <= tlo3;
      thi4 <= thi3;
    end
  end

  // stage 5: offset from centre to closest point, far check
  always_comb begin
    far_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      e_full[i] = 40'(d4[i]) - 40'($signed(q4[i][54:16]));
      if (e_full[i] >= 40'sd16777216 || e_full[i] <= -40'sd16777216) far_c = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        e5[i] <= e_full[i][24:0];
      end
      far5 <= far_c;
      u5 <= u4;
      tlo5 <= tlo4;
      thi5 <= thi4;
    end
  end

  // stage 6: squares
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= 48'(50'(e5[i]) * 50'(e5[i]));
      end
      far6 <= far5;
      u6 <= u5;
      tlo6 <= tlo5;
      thi6 <= thi5;
    end
  end

  // stage 7: discriminant
  always_comb begin
    sum7 = 50'(sq6[0]) + 50'(sq6[1]) + 50'(sq6[2]);
    disc7 = $signed({5'b0, radius_sq}) - $signed({2'b0, sum7[49:16]});
    geo_next.miss = far6 || disc7[35];
    geo_next.disc = disc7[30:0];
    geo_next.u    = u6;
    geo_next.t_lo = tlo6;
    geo_next.t_hi = thi6;
  end
  always_ff @(posedge clk) begin
    if (rdy[7]) out_geo <= geo_next;
  end
  assign out_valid = v[7];

endmodule

/* sv/rsi_sqrt_step.sv */
// one pipeline stage of the digit-by-digit square root, several result bits
// depends on rsi_pkg
module rsi_sqrt_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsi_pkg::sq_t   in_sq,
  output logic           out_valid,
  input  logic           out_ready,
  output rsi_pkg::sq_t   out_sq
);
  import rsi_pkg::*;

  logic [REM_W-1:0] rem_w;
  logic [ROOT_W-1:0] root_w;
  logic [RAD_W-1:0] rad_w;
  logic [ROOT_W+1:0] test_w;
  sq_t sq_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    rem_w  = in_sq.rem;
    root_w = in_sq.root;
    rad_w  = in_sq.rad;
    test_w = '0;
    for (int j = 0; j < SQ_BITS; j++) begin
      rem_w  = {rem_w[REM_W-3:0], rad_w[RAD_W-1:RAD_W-2]};
      rad_w  = {rad_w[RAD_W-3:0], 2'b00};
      test_w = {root_w, 2'b01};
      if (rem_w >= REM_W'(test_w)) begin
        rem_w  = rem_w - REM_W'(test_w);
        root_w = {root_w[ROOT_W-2:0], 1'b1};
      end else begin
        root_w = {root_w[ROOT_W-2:0], 1'b0};
      end
    end
    sq_next.rem  = rem_w;
    sq_next.root = root_w;
    sq_next.rad  = rad_w;
    sq_next.ctx  = in_sq.ctx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_sq <= sq_next;
  end

endmodule

/* sv/ray_sphere_intersect.sv */
// ray against sphere intersection, signed q16.16, fully pipelined
// depends on rsi_pkg, rsi_geom, rsi_sqrt_step
//
// channel  dir  fields (lowest bit up)
// s_axis   in   origin_x 32, origin_y 32, origin_z 32, dir_x 18, dir_y 18, dir_z 18,
//               t_min 31, t_max 31, 4 zero pad bits
// m_axis   out  hit 1, distance 31, far_root 1, 7 zero pad bits
// cfg      in   cfg_we, cfg_index (register number), cfg_data
//
// pipeline of 7 geometry stages, 6 square root stages of 4 root bits each and
// one output register
// one item per cycle sustained while m_tready is high; each stage holds its
// item only while the next one is full and stalled, so bubbles close up under
// back pressure
// sync rst clears all valid bits, centre and min_t_floor; radius_sq resets to 1.0
module ray_sphere_intersect (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
  input  logic [rsi_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // hit, distance, far_root
  output logic [rsi_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import rsi_pkg::*;

  // sphere registers
  logic signed [CRD_W-1:0] centre_x, centre_y, centre_z;
  logic [T_W-1:0] radius_sq, min_t_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x    <= '0;
      centre_y    <= '0;
      centre_z    <= '0;
      radius_sq   <= RSQ_RESET;
      min_t_floor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE_X:    centre_x    <= cfg_data;
        REG_CENTRE_Y:    centre_y    <= cfg_data;
        REG_CENTRE_Z:    centre_z    <= cfg_data;
        REG_RADIUS_SQ:   radius_sq   <= cfg_data[T_W-1:0];
        REG_MIN_T_FLOOR: min_t_floor <= cfg_data[T_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry front end
  logic geo_valid, geo_ready;
  geo_t geo;

  rsi_geom u_geom (
    .clk         (clk),
    .rst         (rst),
    .centre_x    (centre_x),
    .centre_y    (centre_y),
    .centre_z    (centre_z),
    .radius_sq   (radius_sq),
    .min_t_floor (min_t_floor),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .origin_x    ($signed(s_tdata[31:0])),
    .origin_y    ($signed(s_tdata[63:32])),
    .origin_z    ($signed(s_tdata[95:64])),
    .dir_x       ($signed(s_tdata[113:96])),
    .dir_y       ($signed(s_tdata[131:114])),
    .dir_z       ($signed(s_tdata[149:132])),
    .t_min       (s_tdata[180:150]),
    .t_max       (s_tdata[211:181]),
    .out_valid   (geo_valid),
    .out_ready   (geo_ready),
    .out_geo     (geo)
  );

  // square root chain over disc * 2^16
  logic sv [SQ_STEPS+1];
  logic sr [SQ_STEPS+1];
  sq_t  sd [SQ_STEPS+1];

  assign sv[0] = geo_valid;
  assign geo_ready = sr[0];
  always_comb begin
    sd[0].rem  = '0;
    sd[0].root = '0;
    sd[0].rad  = {1'b0, geo.disc, 16'b0};
    sd[0].ctx  = geo;
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    rsi_sqrt_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[g]),
      .in_ready  (sr[g]),
      .in_sq     (sd[g]),
      .out_valid (sv[g+1]),
      .out_ready (sr[g+1]),
      .out_sq    (sd[g+1])
    );
  end

  // root selection against the accepted range
  logic signed [U_W:0] t0, t1, lo_s, hi_s;
  logic ok0, ok1;
  logic hit_next, far_next;
  logic [T_W-1:0] dist_next;
  logic hit, far_root;
  logic [T_W-1:0] distance;
  geo_t fin;

  always_comb begin
    fin  = sd[SQ_STEPS].ctx;
    t0   = (U_W+1)'(fin.u) - $signed({14'b0, sd[SQ_STEPS].root});
    t1   = (U_W+1)'(fin.u) + $signed({14'b0, sd[SQ_STEPS].root});
    lo_s = $signed({7'b0, fin.t_lo});
    hi_s = $signed({7'b0, fin.t_hi});
    ok0  = !fin.miss && t0 >= lo_s && t0 <= hi_s;
    ok1  = !fin.miss && t1 >= lo_s && t1 <= hi_s;
    hit_next  = ok0 || ok1;
    far_next  = !ok0 && ok1;
    dist_next = ok0 ? t0[T_W-1:0] : (ok1 ? t1[T_W-1:0] : '0);
  end

  // output register
  assign sr[SQ_STEPS] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sr[SQ_STEPS]) begin
      m_tvalid <= sv[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (sr[SQ_STEPS]) begin
      hit      <= hit_next;
      far_root <= far_next;
      distance <= dist_next;
    end
  end

  assign m_tdata = {7'b0, far_root, distance, hit};

`ifndef ASSERT_OFF
  // a miss carries a zero distance and no far flag
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !hit |-> distance == '0 && !far_root)
    else $error("miss with nonzero distance or far flag");

  // far root only reported on a hit
  a_far_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && far_root |-> hit)
    else $error("far root without hit");

  // reset restores the unit sphere
  a_reset_rsq: assert property (@(posedge clk)
    rst |=> radius_sq == RSQ_RESET)
    else $error("radius_sq not at reset value");
`endif

endmodule
